/* design/decimal_lsd_radix_sort_assert.svh */
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sort assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DECIMAL_LSD_RADIX_SORT_ASSERT_SVH
`define DECIMAL_LSD_RADIX_SORT_ASSERT_SVH

// same-cycle implication
`define DRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/drs_pkg.sv */
// ----------------------------------------------------------------------------
// drs_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

  // fixed field width of the value channels
  localparam int unsigned VALUE_W     = 31;
  // decimal digits held per item, enough for any 31-bit value
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int unsigned DIGIT_IDX_W = 4;

  typedef logic [DIGIT_W-1:0]     digit_t;
  typedef logic [DIGIT_IDX_W-1:0] dpos_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch input beat, start bcd conversion
    logic dd_step;    // one double-dabble step
    logic store;      // write converted item to the data bank
    logic pass_init;  // clear digit counts, start a pass
    logic count_run;  // histogram walk
    logic prefix;     // one prefix-sum step
    logic scatter;    // stable scatter walk
    logic pass_end;   // swap banks, next digit
    logic out_init;   // rewind for streaming
    logic out_run;    // stream sorted items
    logic finish;     // clear set state
  } drs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic conv_done;
    logic last;
    logic idx_done;
    logic prefix_done;
    logic sort_more;
    logic out_done;
  } drs_sts_t;

endpackage

`default_nettype wire

/* design/drs_if.sv */
// ----------------------------------------------------------------------------
// drs stream interfaces
// valid/ready channels for input values and sorted results
// ----------------------------------------------------------------------------
`default_nettype none

interface drs_in_if;
  logic                        valid;
  logic                        ready;
  logic [drs_pkg::VALUE_W-1:0] value;
  logic                        last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface drs_out_if;
  logic                        valid;
  logic                        ready;
  logic [drs_pkg::VALUE_W-1:0] sorted_value;
  logic                        last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

`default_nettype wire

/* design/drs_ctrl.sv */
// ----------------------------------------------------------------------------
// drs_ctrl
// sequencer for load, digit passes and result streaming
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ctrl import drs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  drs_sts_t sts_i,
  output drs_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CONV,
    ST_CHECK,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts_i.full || sts_i.conv_done) begin
          // a beat that finds the buffer full is dropped
          cmd_o.store = !sts_i.full;
          state_d     = sts_i.last ? ST_CHECK : ST_LOAD;
        end else begin
          cmd_o.dd_step = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts_i.sort_more) begin
          cmd_o.pass_init = 1'b1;
          state_d         = ST_COUNT;
        end else begin
          cmd_o.out_init = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_COUNT: begin
        cmd_o.count_run = 1'b1;
        if (sts_i.idx_done) state_d = ST_PREFIX;
      end
      ST_PREFIX: begin
        cmd_o.prefix = 1'b1;
        if (sts_i.prefix_done) state_d = ST_SCATTER;
      end
      ST_SCATTER: begin
        cmd_o.scatter = 1'b1;
        if (sts_i.idx_done) begin
          cmd_o.pass_end = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_OUT: begin
        cmd_o.out_run = 1'b1;
        if (sts_i.out_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/drs_dp.sv */
// ----------------------------------------------------------------------------
// drs_dp
// bcd conversion, ping-pong item banks, digit counters and output register
// ----------------------------------------------------------------------------
`default_nettype none

module drs_dp import drs_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VALUE_W-1:0] in_value_i,
  input  logic               in_last_i,
  input  drs_cmd_t           cmd_i,
  output drs_sts_t           sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [VALUE_W-1:0] out_value_o,
  output logic               out_last_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned SW = $clog2(VALUE_BITS + 1);
  localparam int unsigned EW = VALUE_BITS + BCD_W;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);
  localparam logic [SW-1:0] NumSteps = SW'(VALUE_BITS);
  localparam dpos_t         NumDig   = DIGIT_IDX_W'(NUM_DIGITS);

  // digit at a given decimal position
  function automatic digit_t digit_at(input logic [BCD_W-1:0] bcd, input dpos_t pos);
    digit_t d;
    d = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (pos == DIGIT_IDX_W'(k)) d = bcd[k*DIGIT_W +: DIGIT_W];
    end
    return d;
  endfunction

  // number of significant decimal digits
  function automatic dpos_t digit_count(input logic [BCD_W-1:0] bcd);
    dpos_t n;
    n = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd[k*DIGIT_W +: DIGIT_W] != '0) n = DIGIT_IDX_W'(k + 1);
    end
    return n;
  endfunction

  // conversion registers
  logic [VALUE_BITS-1:0] val_q, bin_q;
  logic [BCD_W-1:0]      bcd_q, bcd_adj;
  logic [SW-1:0]         step_q;
  logic                  last_q;

  // sort control registers
  logic [CW-1:0] cnt_q, idx_q;
  dpos_t         ndig_q, pass_q, pre_q, ndig_new;
  logic          bank_q, rd_vld_q;
  logic [CW-1:0] counts_q [NUM_DIGITS];
  logic [CW-1:0] counts_d [NUM_DIGITS];

  // item banks
  logic [EW-1:0] mem0 [MAX_ITEMS];
  logic [EW-1:0] mem1 [MAX_ITEMS];
  logic [EW-1:0] rd0_q, rd1_q, rd_ent, wdata;

  // output register
  logic                  out_valid_q, out_last_q;
  logic [VALUE_BITS-1:0] out_value_q;

  logic [VALUE_BITS-1:0] rd_value;
  logic [BCD_W-1:0]      rd_bcd;
  digit_t                rd_digit;
  logic [CW-1:0]         cur_cnt, raddr_full, scat_addr_full;
  logic [AW-1:0]         raddr, waddr;
  logic                  slot_free, issue_cs, issue_out, issue, scat_wr, we0, we1;

  // read side decode
  assign rd_ent   = bank_q ? rd1_q : rd0_q;
  assign rd_value = rd_ent[EW-1:BCD_W];
  assign rd_bcd   = rd_ent[BCD_W-1:0];
  assign rd_digit = digit_at(rd_bcd, pass_q);

  always_comb begin
    cur_cnt = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (rd_digit == DIGIT_W'(k)) cur_cnt = counts_q[k];
    end
  end

  // read issue: count and scatter walk down, streaming walks up
  assign slot_free  = !out_valid_q || out_ready_i;
  assign issue_cs   = (cmd_i.count_run || cmd_i.scatter) && (idx_q != '0);
  assign issue_out  = cmd_i.out_run && (idx_q != cnt_q) && slot_free && !rd_vld_q;
  assign issue      = issue_cs || issue_out;
  assign raddr_full = issue_out ? idx_q : idx_q - CW'(1);
  assign raddr      = raddr_full[AW-1:0];

  // write side: item store into the live bank, scatter into the other one
  assign scat_wr        = cmd_i.scatter && rd_vld_q;
  assign scat_addr_full = cur_cnt - CW'(1);
  assign waddr          = cmd_i.store ? cnt_q[AW-1:0] : scat_addr_full[AW-1:0];
  assign wdata          = cmd_i.store ? {val_q, bcd_q} : rd_ent;
  assign we0            = (cmd_i.store && !bank_q) || (scat_wr && bank_q);
  assign we1            = (cmd_i.store && bank_q) || (scat_wr && !bank_q);

  always_ff @(posedge clk_i) begin
    if (we0) mem0[waddr] <= wdata;
    rd0_q <= mem0[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) mem1[waddr] <= wdata;
    rd1_q <= mem1[raddr];
  end

  // double-dabble adjust: add three to every digit of five or more
  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_q[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign ndig_new = digit_count(bcd_q);

  // digit counters: histogram, prefix sums, scatter decrement
  always_comb begin
    counts_d = counts_q;
    if (cmd_i.pass_init) begin
      for (int k = 0; k < NUM_DIGITS; k++) counts_d[k] = '0;
    end else if (cmd_i.count_run && rd_vld_q) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (rd_digit == DIGIT_W'(k)) counts_d[k] = counts_q[k] + CW'(1);
      end
    end else if (scat_wr) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (rd_digit == DIGIT_W'(k)) counts_d[k] = counts_q[k] - CW'(1);
      end
    end else if (cmd_i.prefix) begin
      for (int k = 1; k < NUM_DIGITS; k++) begin
        if (pre_q == DIGIT_IDX_W'(k)) counts_d[k] = counts_q[k] + counts_q[k-1];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ndig_q      <= '0;
      pass_q      <= '0;
      pre_q       <= '0;
      bank_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_DIGITS; k++) counts_q[k] <= '0;
    end else begin
      counts_q <= counts_d;
      rd_vld_q <= issue;

      if (cmd_i.load) step_q <= NumSteps;
      else if (cmd_i.dd_step) step_q <= step_q - SW'(1);

      if (cmd_i.store) begin
        cnt_q <= cnt_q + CW'(1);
        if (ndig_new > ndig_q) ndig_q <= ndig_new;
      end

      if (cmd_i.pass_init || cmd_i.prefix) idx_q <= cnt_q;
      else if (cmd_i.out_init) idx_q <= '0;
      else if (issue_out) idx_q <= idx_q + CW'(1);
      else if (issue_cs) idx_q <= idx_q - CW'(1);

      if (cmd_i.pass_init) pre_q <= DIGIT_IDX_W'(1);
      else if (cmd_i.prefix && pre_q != NumDig) pre_q <= pre_q + DIGIT_IDX_W'(1);

      if (cmd_i.pass_end) begin
        bank_q <= ~bank_q;
        pass_q <= pass_q + DIGIT_IDX_W'(1);
      end

      if (cmd_i.finish) begin
        cnt_q  <= '0;
        ndig_q <= '0;
        pass_q <= '0;
      end

      if (cmd_i.out_run && rd_vld_q) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= in_value_i[VALUE_BITS-1:0];
      bin_q  <= in_value_i[VALUE_BITS-1:0];
      bcd_q  <= '0;
      last_q <= in_last_i;
    end else if (cmd_i.dd_step) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
    end
    if (cmd_i.out_run && rd_vld_q) begin
      out_value_q <= rd_value;
      out_last_q  <= (idx_q == cnt_q);
    end
  end

  // status
  assign sts_o.full        = (cnt_q == MaxCount);
  assign sts_o.conv_done   = (step_q == '0);
  assign sts_o.last        = last_q;
  assign sts_o.idx_done    = (idx_q == '0) && !rd_vld_q;
  assign sts_o.prefix_done = (pre_q == NumDig);
  assign sts_o.sort_more   = (pass_q < ndig_q);
  assign sts_o.out_done    = rd_vld_q && (idx_q == cnt_q);

  assign out_valid_o = out_valid_q;
  assign out_value_o = VALUE_W'(out_value_q);
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* design/decimal_lsd_radix_sort.sv */
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sort
// buffered decimal lsd radix sort of up to MAX_ITEMS values
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  in_i     in   valid/ready  value[30:0], last_in
//  out_o    out  valid/ready  sorted_value[30:0], last_out
//
//  each beat is converted by a one-bit-per-cycle binary to bcd converter before
//  the next beat is taken; a beat arriving with the buffer full is dropped.
//  the beat marked last_in starts the sort: d passes, d = digits of the largest
//  value, each made of pass start, count walk, ten prefix steps and scatter walk,
//  the walks bound by the single read port of each item bank.
//  results then stream out while out_o.ready holds high, one bank read at a time;
//  a stall on out_o freezes the stream. no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_lsd_radix_sort_assert.svh"

module decimal_lsd_radix_sort import drs_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  drs_in_if.sink    in_i,
  drs_out_if.source out_o
);

  drs_cmd_t   cmd;
  drs_sts_t   sts;
  logic       in_ready;
  logic [4:0] dp_ops;

  // sequencer
  drs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  drs_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (in_i.value),
    .in_last_i   (in_i.last_in),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_value_o (out_o.sorted_value),
    .out_last_o  (out_o.last_out)
  );

  assign in_i.ready = in_ready;

  // datapath walks that must never overlap
  assign dp_ops = {cmd.dd_step, cmd.count_run, cmd.prefix, cmd.scatter, cmd.out_run};

  // checks
  `DRS_ASSERT_IMPL(a_no_store_full, cmd.store, !sts.full, "item stored into full buffer")
  `DRS_ASSERT_IMPL(a_one_walk, 1'b1, $onehot0(dp_ops), "datapath ops overlap")
  `DRS_ASSERT_NEXT(a_conv_start, cmd.load, !sts.conv_done, "conversion not restarted on load")

endmodule

`default_nettype wire
